### sv/qai_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qai_pkg;

    localparam int unsigned QW   = 16;   // quaternion and rate field width
    localparam int unsigned PW   = 32;   // q * rate product width
    localparam int unsigned SW   = 34;   // derivative sum width
    localparam int unsigned DW   = 51;   // derivative sum times time step
    localparam int unsigned NW   = 52;   // unnormalized component width
    localparam int unsigned MW   = 28;   // rounded component width
    localparam int unsigned SQW  = 56;   // component square width
    localparam int unsigned XW   = 64;   // radicand width
    localparam int unsigned RW   = 32;   // root width
    localparam int unsigned DNW  = 48;   // dividend width
    localparam int unsigned QTW  = 18;   // quotient width
    localparam int unsigned RND  = 22;   // rounding shift of the component
    localparam int unsigned DIVS = 19;   // dividend left shift

    localparam logic [15:0] TIME_STEP_RESET = 16'd655;

    typedef struct packed {
        logic signed [QW-1:0] orient_w;
        logic signed [QW-1:0] orient_x;
        logic signed [QW-1:0] orient_y;
        logic signed [QW-1:0] orient_z;
        logic signed [QW-1:0] rate_x;
        logic signed [QW-1:0] rate_y;
        logic signed [QW-1:0] rate_z;
    } qai_in_t;

    typedef struct packed {
        logic signed [QW-1:0] new_w;
        logic signed [QW-1:0] new_x;
        logic signed [QW-1:0] new_y;
        logic signed [QW-1:0] new_z;
        logic                 zero_norm;
    } qai_out_t;

endpackage

`default_nettype wire

### sv/quaternion_attitude_integrate.sv
`timescale 1ns / 1ps
`default_nettype none

// First-order quaternion attitude integrator. Each item carries an orientation
// quaternion (signed Q1.14) and a body angular rate (signed Q4.11 rad/s). The
// block adds half of q times (0, w), scaled by time_step (unsigned Q0.16 s,
// reset value 655), to q, normalizes the sum by the root of its sum of squares
// and returns the unit quaternion, saturated to Q1.14. A zero magnitude gives
// zero fields with zero_norm set. The block is fully pipelined: one item is
// accepted per cycle while the output is not stalled, its depth being set by
// the 32 one-bit steps of the square root and the 18 one-bit steps of the
// four parallel dividers. A stalled output holds the whole pipeline, but the
// input register still takes an item while it is empty.
// Write time_step only while no item is in flight.
module quaternion_attitude_integrate
    import qai_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire qai_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output qai_out_t         m_data
);

    localparam int unsigned SQ_STEPS  = RW;
    localparam int unsigned DIV_STEPS = QTW;

    logic [15:0] time_step_reg;

    // Input register.
    logic    v0_reg;
    qai_in_t in0_reg;

    // The pipeline moves as a whole when the output register can take a result.
    logic en;
    logic ld0;
    assign en      = !m_valid || m_ready;
    assign ld0     = en || !v0_reg;
    assign s_ready = ld0;

    // Product stage.
    logic                 v1_reg;
    logic signed [PW-1:0] p1_reg [12];
    logic signed [QW-1:0] q1_reg [4];

    // Derivative sum stage.
    logic                 v2_reg;
    logic signed [SW-1:0] s2_reg [4];
    logic signed [QW-1:0] q2_reg [4];

    // Time step product stage.
    logic                 v3_reg;
    logic signed [DW-1:0] d3_reg [4];
    logic signed [QW-1:0] q3_reg [4];

    // Rounded component stage.
    logic                 v4_reg;
    logic signed [MW-1:0] m4_reg [4];

    // Square stage.
    logic                 v5_reg;
    logic [SQW-1:0]       sq5_reg [4];
    logic signed [MW-1:0] m5_reg [4];

    // Square root stages; index 0 holds the radicand.
    logic                 sv_reg   [SQ_STEPS+1];
    logic [XW-1:0]        srem_reg [SQ_STEPS+1];
    logic [RW-1:0]        sroot_reg[SQ_STEPS+1];
    logic                 szero_reg[SQ_STEPS+1];
    logic signed [MW-1:0] sm_reg   [SQ_STEPS+1][4];

    // Divider stages; index 0 holds the dividend.
    logic                 dv_reg   [DIV_STEPS+1];
    logic [RW:0]          dd_reg   [DIV_STEPS+1];
    logic                 dzero_reg[DIV_STEPS+1];
    logic [DNW-1:0]       drem_reg [DIV_STEPS+1][4];
    logic [QTW-1:0]       dq_reg   [DIV_STEPS+1][4];
    logic                 dneg_reg [DIV_STEPS+1][4];

    qai_out_t out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RESET;
        end else if (cfg_wr_en) begin
            time_step_reg <= cfg_wr_data;
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            m_valid <= 1'b0;
            for (int j = 0; j <= SQ_STEPS; j++) begin
                sv_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= DIV_STEPS; j++) begin
                dv_reg[j] <= 1'b0;
            end
        end else begin
            if (ld0) begin
                v0_reg <= s_valid;
            end
            if (en) begin
                v1_reg    <= v0_reg;
                v2_reg    <= v1_reg;
                v3_reg    <= v2_reg;
                v4_reg    <= v3_reg;
                v5_reg    <= v4_reg;
                sv_reg[0] <= v5_reg;
                for (int j = 0; j < SQ_STEPS; j++) begin
                    sv_reg[j+1] <= sv_reg[j];
                end
                dv_reg[0] <= sv_reg[SQ_STEPS];
                for (int j = 0; j < DIV_STEPS; j++) begin
                    dv_reg[j+1] <= dv_reg[j];
                end
                m_valid <= dv_reg[DIV_STEPS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            in0_reg <= s_data;
        end
    end

    // Front end: products, derivative sums, time step scaling, rounding, squares.
    always_ff @(posedge aclk) begin
        logic signed [NW-1:0] n;
        logic [MW+RND:0]      t;
        logic [SQW+1:0]       psum;
        if (en) begin
            p1_reg[0]  <= in0_reg.orient_x * in0_reg.rate_x;
            p1_reg[1]  <= in0_reg.orient_y * in0_reg.rate_y;
            p1_reg[2]  <= in0_reg.orient_z * in0_reg.rate_z;
            p1_reg[3]  <= in0_reg.orient_w * in0_reg.rate_x;
            p1_reg[4]  <= in0_reg.orient_y * in0_reg.rate_z;
            p1_reg[5]  <= in0_reg.orient_z * in0_reg.rate_y;
            p1_reg[6]  <= in0_reg.orient_w * in0_reg.rate_y;
            p1_reg[7]  <= in0_reg.orient_x * in0_reg.rate_z;
            p1_reg[8]  <= in0_reg.orient_z * in0_reg.rate_x;
            p1_reg[9]  <= in0_reg.orient_w * in0_reg.rate_z;
            p1_reg[10] <= in0_reg.orient_x * in0_reg.rate_y;
            p1_reg[11] <= in0_reg.orient_y * in0_reg.rate_x;
            q1_reg[0]  <= in0_reg.orient_w;
            q1_reg[1]  <= in0_reg.orient_x;
            q1_reg[2]  <= in0_reg.orient_y;
            q1_reg[3]  <= in0_reg.orient_z;

            // The scalar term carries the negative sign of the product.
            s2_reg[0] <= -(SW'(p1_reg[0]) + SW'(p1_reg[1]) + SW'(p1_reg[2]));
            s2_reg[1] <= SW'(p1_reg[3]) + SW'(p1_reg[4]) - SW'(p1_reg[5]);
            s2_reg[2] <= SW'(p1_reg[6]) - SW'(p1_reg[7]) + SW'(p1_reg[8]);
            s2_reg[3] <= SW'(p1_reg[9]) + SW'(p1_reg[10]) - SW'(p1_reg[11]);
            q2_reg    <= q1_reg;

            for (int i = 0; i < 4; i++) begin
                d3_reg[i] <= DW'(s2_reg[i] * $signed({1'b0, time_step_reg}));
            end
            q3_reg <= q2_reg;

            // Round to nearest, ties up: floor((n + 2^21) / 2^22).
            for (int i = 0; i < 4; i++) begin
                n = $signed({q3_reg[i], 28'b0}) + NW'(d3_reg[i]);
                t = (MW+RND+1)'((n + (NW'(1) <<< (RND-1))) >>> RND);
                m4_reg[i] <= t[MW-1:0];
            end

            for (int i = 0; i < 4; i++) begin
                sq5_reg[i] <= SQW'(m4_reg[i] * m4_reg[i]);
            end
            m5_reg <= m4_reg;

            psum = (SQW+2)'(sq5_reg[0]) + (SQW+2)'(sq5_reg[1])
                 + (SQW+2)'(sq5_reg[2]) + (SQW+2)'(sq5_reg[3]);
            srem_reg[0]  <= {psum[SQW-1:0], 8'b0};
            sroot_reg[0] <= '0;
            szero_reg[0] <= (psum == '0);
            sm_reg[0]    <= m5_reg;
        end
    end

    // Square root, one result bit per stage, most significant first.
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        localparam int unsigned B = SQ_STEPS - 1 - j;
        logic [XW+1:0] trial;
        assign trial = ((XW+2)'(sroot_reg[j]) << (B+1)) + ((XW+2)'(1) << (2*B));
        always_ff @(posedge aclk) begin
            if (en) begin
                if ((XW+2)'(srem_reg[j]) >= trial) begin
                    srem_reg[j+1]  <= srem_reg[j] - trial[XW-1:0];
                    sroot_reg[j+1] <= sroot_reg[j] | (RW'(1) << B);
                end else begin
                    srem_reg[j+1]  <= srem_reg[j];
                    sroot_reg[j+1] <= sroot_reg[j];
                end
                szero_reg[j+1] <= szero_reg[j];
                sm_reg[j+1]    <= sm_reg[j];
            end
        end
    end

    // Divider set-up: quotient of (|m| * 2^19 + r) by 2r rounds half away.
    always_ff @(posedge aclk) begin
        logic [MW-1:0] mag;
        if (en) begin
            dd_reg[0]    <= {sroot_reg[SQ_STEPS], 1'b0};
            dzero_reg[0] <= szero_reg[SQ_STEPS];
            for (int i = 0; i < 4; i++) begin
                mag = sm_reg[SQ_STEPS][i][MW-1] ? MW'(-sm_reg[SQ_STEPS][i])
                                                : MW'(sm_reg[SQ_STEPS][i]);
                drem_reg[0][i] <= (DNW'(mag) << DIVS) + DNW'(sroot_reg[SQ_STEPS]);
                dq_reg[0][i]   <= '0;
                dneg_reg[0][i] <= sm_reg[SQ_STEPS][i][MW-1];
            end
        end
    end

    // Restoring division, one quotient bit per stage for all four components.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int unsigned B = DIV_STEPS - 1 - j;
        logic [DNW+QTW:0] dsh;
        assign dsh = (DNW+QTW+1)'(dd_reg[j]) << B;
        always_ff @(posedge aclk) begin
            if (en) begin
                dd_reg[j+1]    <= dd_reg[j];
                dzero_reg[j+1] <= dzero_reg[j];
                dneg_reg[j+1]  <= dneg_reg[j];
                for (int i = 0; i < 4; i++) begin
                    if ((DNW+QTW+1)'(drem_reg[j][i]) >= dsh) begin
                        drem_reg[j+1][i] <= drem_reg[j][i] - dsh[DNW-1:0];
                        dq_reg[j+1][i]   <= dq_reg[j][i] | (QTW'(1) << B);
                    end else begin
                        drem_reg[j+1][i] <= drem_reg[j][i];
                        dq_reg[j+1][i]   <= dq_reg[j][i];
                    end
                end
            end
        end
    end

    // Sign, saturation and zero magnitude handling.
    always_comb begin
        logic signed [QTW:0] v [4];
        logic [QW-1:0]       f [4];
        for (int i = 0; i < 4; i++) begin
            v[i] = dneg_reg[DIV_STEPS][i] ? -$signed({1'b0, dq_reg[DIV_STEPS][i]})
                                          :  $signed({1'b0, dq_reg[DIV_STEPS][i]});
            if (dzero_reg[DIV_STEPS]) begin
                f[i] = '0;
            end else if (v[i] > (QTW+1)'(32767)) begin
                f[i] = 16'h7FFF;
            end else if (v[i] < -(QTW+1)'(32768)) begin
                f[i] = 16'h8000;
            end else begin
                f[i] = v[i][QW-1:0];
            end
        end
        out_next.new_w     = f[0];
        out_next.new_x     = f[1];
        out_next.new_y     = f[2];
        out_next.new_z     = f[3];
        out_next.zero_norm = dzero_reg[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data <= out_next;
        end
    end

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_norm |-> m_data.new_w == '0 && m_data.new_x == '0
                                        && m_data.new_y == '0 && m_data.new_z == '0)
        else $error("zero magnitude result with nonzero fields");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && !v0_reg)
        else $error("pipeline not empty after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(sv_reg[SQ_STEPS]) && $stable(dv_reg[DIV_STEPS]))
        else $error("pipeline moved during a stall");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v0_reg)
        else $error("accepted item not held in the input register");

endmodule

`default_nettype wire
